// ===== rtl/cltb_pkg.sv =====
// Shared types and constants for the consensus log tail buffer.
package cltb_pkg;

   // Ring depth must be a power of two: slots are addressed by the low index bits.
   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int MODE_W     = 3;
   localparam int IDX_W      = 63;
   localparam int TERM_W     = 63;
   localparam int STATUS_W   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND      = 3'd0,
      MODE_QUERY       = 3'd1,
      MODE_STABLE      = 3'd2,
      MODE_SNAP_STABLE = 3'd3,
      MODE_RESTORE     = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_GAP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  index;
      logic [TERM_W-1:0] term;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              term_found;
      logic [TERM_W-1:0] found_term;
      logic              first_valid;
      logic [IDX_W-1:0]  first_index;
      logic              last_valid;
      logic [IDX_W-1:0]  last_index;
      logic [CNT_W-1:0]  held_count;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [TERM_W-1:0]  data;
   } wr_type;

endpackage

// ===== rtl/cltb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cltb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cltb_exec.sv =====
// Per-transaction operation logic and the log tail bookkeeping registers.
module cltb_exec import cltb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  req_type           req,
   input  logic [TERM_W-1:0] rd_term,
   output wr_type            wr,
   output rsp_type           rsp
);

   localparam int IDXX_W = IDX_W + 1;

   logic [IDX_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic              snap_present_ff, snap_present_in;
   logic [IDX_W-1:0]  snap_index_ff, snap_index_in;
   logic [TERM_W-1:0] snap_term_ff, snap_term_in;

   logic [IDXX_W-1:0] idx_x, base_x, end_x, off_x;
   logic              in_range, snap_hit;

   // Unwrapped compares: base + count can pass 2^63.
   assign idx_x    = {1'b0, req.index};
   assign base_x   = {1'b0, base_ff};
   assign end_x    = base_x + IDXX_W'(count_ff);
   assign off_x    = idx_x - base_x;
   assign in_range = (idx_x >= base_x) && (idx_x < end_x);
   assign snap_hit = snap_present_ff && (snap_index_ff == req.index);

   always_comb begin
      base_in         = base_ff;
      count_in        = count_ff;
      last_in         = last_ff;
      snap_present_in = snap_present_ff;
      snap_index_in   = snap_index_ff;
      snap_term_in    = snap_term_ff;
      wr.en           = 1'b0;
      wr.addr         = req.index[RING_AW-1:0];
      wr.data         = req.term;
      rsp.status      = ST_OK;
      rsp.term_found  = 1'b0;
      rsp.found_term  = '0;

      case (mode_type'(req.mode))
         MODE_APPEND: begin
            if (idx_x == end_x) begin
               if (count_ff == CNT_W'(RING_DEPTH)) begin
                  rsp.status = ST_FULL;
               end else begin
                  wr.en    = fire;
                  count_in = count_ff + CNT_W'(1);
                  last_in  = req.index;
               end
            end else if (idx_x <= base_x) begin
               // replace the whole tail with this one entry
               wr.en    = fire;
               count_in = CNT_W'(1);
               base_in  = req.index;
               last_in  = req.index;
            end else if (idx_x > end_x) begin
               rsp.status = ST_GAP;
            end else begin
               // truncate from this index, then append
               wr.en    = fire;
               count_in = off_x[CNT_W-1:0] + CNT_W'(1);
               last_in  = req.index;
            end
         end
         MODE_QUERY: begin
            if (idx_x < base_x) begin
               rsp.term_found = snap_hit;
               rsp.found_term = snap_hit ? snap_term_ff : '0;
            end else begin
               rsp.term_found = in_range;
               rsp.found_term = in_range ? rd_term : '0;
            end
         end
         MODE_STABLE: begin
            if (in_range && (rd_term == req.term)) begin
               count_in = count_ff - off_x[CNT_W-1:0] - CNT_W'(1);
               base_in  = req.index + IDX_W'(1);
            end
         end
         MODE_SNAP_STABLE: begin
            if (snap_hit) begin
               snap_present_in = 1'b0;
            end
         end
         MODE_RESTORE: begin
            base_in         = req.index + IDX_W'(1);
            count_in        = '0;
            snap_present_in = 1'b1;
            snap_index_in   = req.index;
            snap_term_in    = req.term;
         end
         default: begin
         end
      endcase

      rsp.first_valid = snap_present_in;
      rsp.first_index = snap_present_in ? (snap_index_in + IDX_W'(1)) : '0;
      rsp.last_valid  = (count_in != '0) || snap_present_in;
      if (count_in != '0) begin
         rsp.last_index = last_in;
      end else if (snap_present_in) begin
         rsp.last_index = snap_index_in;
      end else begin
         rsp.last_index = '0;
      end
      rsp.held_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff         <= '0;
         count_ff        <= '0;
         last_ff         <= '0;
         snap_present_ff <= 1'b0;
         snap_index_ff   <= '0;
         snap_term_ff    <= '0;
      end else if (fire) begin
         base_ff         <= base_in;
         count_ff        <= count_in;
         last_ff         <= last_in;
         snap_present_ff <= snap_present_in;
         snap_index_ff   <= snap_index_in;
         snap_term_ff    <= snap_term_in;
      end
   end

endmodule

// ===== rtl/consensus_log_tail_buffer_core.sv =====
// Top level of the consensus log tail buffer: handshakes, staging, ring RAM.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   mode, entry_index, entry_term
//   rsp      out        rsp_valid / rsp_stall   status, term_found, found_term,
//                                               first/last valid+index, held_count
//
// One transaction per cycle sustained while rsp_stall is low. The ring RAM is
// read on accept as the request registers into the operation stage; when that
// stage fires, the operation and state update run and the result register loads.
// Reset is synchronous and active high; no clear pass is needed because ring
// slot data is only used inside the held range.
// A stalled result holds the operation stage; req_stall rises only while both
// the operation stage and the result register are full and rsp_stall is high.
//
// Ring slots are addressed by the low bits of the log index, so any held
// entry's slot is known at accept time without the head pointer.
module consensus_log_tail_buffer_core import cltb_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [TERM_W-1:0]   req_entry_term,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_term_found,
   output logic [TERM_W-1:0]   rsp_found_term,
   output logic                rsp_first_valid,
   output logic [IDX_W-1:0]    rsp_first_index,
   output logic                rsp_last_valid,
   output logic [IDX_W-1:0]    rsp_last_index,
   output logic [CNT_W-1:0]    rsp_held_count
);

   // operation stage
   logic              in_valid_ff, in_valid_in;
   req_type           in_ff;
   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   // same-edge write/read collision bypass
   logic              fwd_hit_ff;
   logic [TERM_W-1:0] fwd_data_ff;

   logic              accept, fire;
   logic [TERM_W-1:0] ram_rd, rd_term;
   wr_type            wr;
   rsp_type           x_rsp;

   assign fire        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   cltb_ram #(
      .WIDTH (TERM_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (req_entry_index[RING_AW-1:0]),
      .rd_data (ram_rd)
   );

   // RAM is read-first; a write at the accept edge to the same slot is forwarded.
   assign rd_term = fwd_hit_ff ? fwd_data_ff : ram_rd;

   cltb_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (in_ff),
      .rd_term (rd_term),
      .wr      (wr),
      .rsp     (x_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_hit_ff <= wr.en && (wr.addr == req_entry_index[RING_AW-1:0]);
         end
      end
      if (accept) begin
         in_ff.mode  <= req_mode;
         in_ff.index <= req_entry_index;
         in_ff.term  <= req_entry_term;
         fwd_data_ff <= wr.data;
      end
      if (fire) begin
         rsp_ff <= x_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_term_found  = rsp_ff.term_found;
   assign rsp_found_term  = rsp_ff.found_term;
   assign rsp_first_valid = rsp_ff.first_valid;
   assign rsp_first_index = rsp_ff.first_index;
   assign rsp_last_valid  = rsp_ff.last_valid;
   assign rsp_last_index  = rsp_ff.last_index;
   assign rsp_held_count  = rsp_ff.held_count;

   // ring never reports more entries than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_held_count <= CNT_W'(RING_DEPTH)))
      else $error("held count exceeds ring depth");

   // held entries always give a last index
   a_last_with_entries: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_held_count != '0)) |-> rsp_last_valid)
      else $error("entries held but last index not valid");

   // only appends can be rejected
   a_status_append_only: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_ff.mode != MODE_APPEND)) |-> (x_rsp.status == ST_OK))
      else $error("non-append operation reported a reject status");

   // input backpressure only comes from a blocked result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked result");

   // a taken result register is refilled or emptied on the next edge
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !fire) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule
